>>> sv/ptpv_pkg.sv
package ptpv_pkg;

    // Quadrant turn applied ahead of the rotation chain
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    // Control that travels down the chain beside the datapath
    typedef struct packed {
        logic  vld;
        logic  zero;
        t_quad quad;
    } t_side;

    localparam int GUARD_BITS  = 8;
    localparam int ANG_FRAC    = 20;
    localparam int ANG_W       = 28;   // accumulated angle, Q20 degrees
    localparam int ANGS_W      = 30;   // angle after quadrant base is added
    localparam int DIR_W       = 16;
    localparam int RW          = 17;   // rounded angle before wrap, signed
    localparam int TABLE_LEN   = 24;

    localparam logic [15:0]          GAIN_HI     = 16'd39796;
    localparam logic [15:0]          GAIN_LO     = 16'd60840;
    localparam logic signed [RW-1:0] DEG_Q7_FULL = 17'sd46080;
    localparam logic [DIR_W-1:0]     DIR_ZERO    = 16'd11520;

    // atan(2^-i) in degrees, Q20
    function automatic logic signed [ANG_W-1:0] atan_q20(input int idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            0:  v = 28'sd47185920;
            1:  v = 28'sd27855475;
            2:  v = 28'sd14718068;
            3:  v = 28'sd7471121;
            4:  v = 28'sd3750058;
            5:  v = 28'sd1876857;
            6:  v = 28'sd938658;
            7:  v = 28'sd469357;
            8:  v = 28'sd234682;
            9:  v = 28'sd117342;
            10: v = 28'sd58671;
            11: v = 28'sd29335;
            12: v = 28'sd14668;
            13: v = 28'sd7334;
            14: v = 28'sd3667;
            15: v = 28'sd1833;
            16: v = 28'sd917;
            17: v = 28'sd458;
            18: v = 28'sd229;
            19: v = 28'sd115;
            20: v = 28'sd57;
            21: v = 28'sd29;
            22: v = 28'sd14;
            23: v = 28'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Quadrant base angle in Q20 degrees
    function automatic logic signed [ANGS_W-1:0] base_q20(input t_quad q);
        logic signed [ANGS_W-1:0] v;
        unique case (q)
            QUAD_0:   v = 30'sd0;
            QUAD_90:  v = 30'sd94371840;
            QUAD_180: v = 30'sd188743680;
            QUAD_270: v = 30'sd283115520;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/ptpv_if.sv
interface ptpv_in_if #(
    parameter int W = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] dest_x;
    logic signed [W-1:0] dest_y;

    modport source (output valid, origin_x, origin_y, dest_x, dest_y, input ready);
    modport sink   (input valid, origin_x, origin_y, dest_x, dest_y, output ready);
endinterface

interface ptpv_out_if #(
    parameter int W = 16
) ();
    logic        valid;
    logic        ready;
    logic [W:0]  distance;
    logic [15:0] direction;

    modport source (output valid, distance, direction, input ready);
    modport sink   (input valid, distance, direction, output ready);
endinterface

>>> sv/point_to_polar_vector_top.sv
// Distance and direction from an origin point to a destination point.
// Path: entry register, rotation cells, gain register, final register, output register.
// Throughput: one item per cycle while not stalled; set by the unrolled rotation cells.
// A two-entry output buffer decouples ready: input ready drops only when it is full.
// Reset (synchronous, active low) empties the chain and the output buffer.
module point_to_polar_vector_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptpv_in_if.sink     i_pt,
    ptpv_out_if.source  o_pv
);

    localparam int W   = COORD_WIDTH;
    localparam int N   = CORDIC_STAGES;
    localparam int XW  = W + 12;        // rotation datapath, headroom for gain
    localparam int UW  = XW - 1;        // final x as unsigned
    localparam int PH  = UW + 16;       // partial product width
    localparam int PW  = PH + 1;        // recombined product width
    localparam int DW  = W + 1;         // distance width
    localparam int ZW  = ptpv_pkg::ANG_W;
    localparam int ZSW = ptpv_pkg::ANGS_W;
    localparam int RW  = ptpv_pkg::RW;

    localparam logic [PW-1:0] DIST_MAX = PW'({DW{1'b1}});

    // Pipeline advance: stalls only when the output buffer is full
    logic en;
    logic r_skid_full;
    assign en         = !r_skid_full;
    assign i_pt.ready = en;

    // ---------------------------------------------------------------
    // Entry stage: difference vector, quadrant turn, guard scaling
    // ---------------------------------------------------------------
    logic signed [W:0]    dx, dy, qx, qy;
    ptpv_pkg::t_quad      n_quad;
    logic signed [XW-1:0] n_x0, n_y0;
    ptpv_pkg::t_side      n_side0;

    assign dx = (W+1)'(i_pt.dest_x) - (W+1)'(i_pt.origin_x);
    assign dy = (W+1)'(i_pt.dest_y) - (W+1)'(i_pt.origin_y);

    always_comb begin
        priority if (dx > 0 && dy >= 0) begin
            qx = dx;  qy = dy;  n_quad = ptpv_pkg::QUAD_0;
        end else if (dx <= 0 && dy > 0) begin
            qx = dy;  qy = -dx; n_quad = ptpv_pkg::QUAD_90;
        end else if (dx < 0 && dy <= 0) begin
            qx = -dx; qy = -dy; n_quad = ptpv_pkg::QUAD_180;
        end else begin
            // fourth quadrant, and the zero vector, which is flagged below
            qx = -dy; qy = dx;  n_quad = ptpv_pkg::QUAD_270;
        end
        n_x0         = XW'(qx) <<< ptpv_pkg::GUARD_BITS;
        n_y0         = XW'(qy) <<< ptpv_pkg::GUARD_BITS;
        n_side0.vld  = i_pt.valid;
        n_side0.zero = (dx == 0) && (dy == 0);
        n_side0.quad = n_quad;
    end

    logic signed [XW-1:0] c_x [0:N];
    logic signed [XW-1:0] c_y [0:N];
    logic signed [ZW-1:0] c_z [0:N];
    ptpv_pkg::t_side      c_side [0:N];

    logic signed [XW-1:0] r_x0, r_y0;
    ptpv_pkg::t_side      r_side0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0 <= n_x0;
            r_y0 <= n_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side0 <= '0;
        end else if (en) begin
            r_side0 <= n_side0;
        end
    end

    assign c_x[0]    = r_x0;
    assign c_y[0]    = r_y0;
    assign c_z[0]    = '0;
    assign c_side[0] = r_side0;

    // ---------------------------------------------------------------
    // Rotation chain: one cell per CORDIC iteration
    // ---------------------------------------------------------------
    for (genvar g = 0; g < N; g++) begin : g_cell
        ptpv_cell #(
            .XW  (XW),
            .IDX (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_x    (c_x[g]),
            .i_y    (c_y[g]),
            .i_z    (c_z[g]),
            .i_side (c_side[g]),
            .o_x    (c_x[g+1]),
            .o_y    (c_y[g+1]),
            .o_z    (c_z[g+1]),
            .o_side (c_side[g+1])
        );
    end

    // ---------------------------------------------------------------
    // Gain stage: x times the CORDIC gain as two 16-bit halves;
    // add the quadrant base and the rounding half to the angle
    // ---------------------------------------------------------------
    logic [UW-1:0]         ux;
    logic [PH-1:0]         r_ph, r_pl;
    logic signed [ZSW-1:0] r_zr;
    ptpv_pkg::t_side       r_side_m;

    assign ux = (c_x[N] > 0) ? UW'(c_x[N]) : '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ph <= PH'(ux) * PH'(ptpv_pkg::GAIN_HI);
            r_pl <= PH'(ux) * PH'(ptpv_pkg::GAIN_LO);
            r_zr <= ZSW'(c_z[N]) + ptpv_pkg::base_q20(c_side[N].quad)
                  + ZSW'(1 << (ptpv_pkg::ANG_FRAC - 8));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_m <= '0;
        end else if (en) begin
            r_side_m <= c_side[N];
        end
    end

    // ---------------------------------------------------------------
    // Final stage: round distance to Q0 (integer) and saturate; round and wrap angle
    // ---------------------------------------------------------------
    logic [PW-1:0]         prod, dfull;
    logic signed [ZSW-1:0] zsh;
    logic signed [RW-1:0]  rr, rw;
    logic [DW-1:0]         n_dist;
    logic [15:0]           n_dir;

    always_comb begin
        prod  = PW'(r_ph) + ((PW'(r_pl) + PW'(32'h8000)) >> 16);
        dfull = (prod + PW'(1 << (15 + ptpv_pkg::GUARD_BITS))) >> (16 + ptpv_pkg::GUARD_BITS);
        zsh   = r_zr >>> (ptpv_pkg::ANG_FRAC - 7);
        rr    = zsh[RW-1:0];
        if (rr < 0) begin
            rw = rr + ptpv_pkg::DEG_Q7_FULL;
        end else if (rr >= ptpv_pkg::DEG_Q7_FULL) begin
            rw = rr - ptpv_pkg::DEG_Q7_FULL;
        end else begin
            rw = rr;
        end
        if (r_side_m.zero) begin
            n_dist = '0;
            n_dir  = ptpv_pkg::DIR_ZERO;
        end else begin
            n_dist = (dfull > DIST_MAX) ? DIST_MAX[DW-1:0] : dfull[DW-1:0];
            n_dir  = rw[15:0];
        end
    end

    logic [DW-1:0] r_fin_dist;
    logic [15:0]   r_fin_dir;
    logic          r_fin_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin_dist <= n_dist;
            r_fin_dir  <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (en) begin
            r_fin_vld <= r_side_m.vld;
        end
    end

    // ---------------------------------------------------------------
    // Output register plus skid entry
    // ---------------------------------------------------------------
    logic          r_out_vld;
    logic [DW-1:0] r_out_dist, r_skid_dist;
    logic [15:0]   r_out_dir, r_skid_dir;
    logic          fin_fire, out_fire;

    assign fin_fire = r_fin_vld && en;
    assign out_fire = r_out_vld && o_pv.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            // drain the skid entry into the output register
            if (out_fire) begin
                r_out_dist  <= r_skid_dist;
                r_out_dir   <= r_skid_dir;
                r_skid_full <= 1'b0;
            end
        end else if (fin_fire) begin
            if (!r_out_vld || out_fire) begin
                r_out_dist <= r_fin_dist;
                r_out_dir  <= r_fin_dir;
                r_out_vld  <= 1'b1;
            end else begin
                // output stalled: hold the item in the skid entry
                r_skid_dist <= r_fin_dist;
                r_skid_dir  <= r_fin_dir;
                r_skid_full <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_pv.valid     = r_out_vld;
    assign o_pv.distance  = r_out_dist;
    assign o_pv.direction = r_out_dir;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_vld)
        else $error("skid entry full while output register empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_vld && !r_skid_full && r_out_vld && !o_pv.ready) |=> r_skid_full)
        else $error("item at final stage lost during output stall");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pv.valid |-> (o_pv.direction < 16'(ptpv_pkg::DEG_Q7_FULL)))
        else $error("direction not wrapped below a full turn");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && o_pv.ready) |=> (!r_skid_full && r_out_vld))
        else $error("skid entry not drained on output accept");

endmodule

>>> sv/ptpv_cell.sv
module ptpv_cell #(
    parameter int XW  = 28,
    parameter int IDX = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic signed [XW-1:0]                  i_x,
    input  logic signed [XW-1:0]                  i_y,
    input  logic signed [ptpv_pkg::ANG_W-1:0]     i_z,
    input  ptpv_pkg::t_side                       i_side,
    output logic signed [XW-1:0]                  o_x,
    output logic signed [XW-1:0]                  o_y,
    output logic signed [ptpv_pkg::ANG_W-1:0]     o_z,
    output ptpv_pkg::t_side                       o_side
);

    localparam logic signed [ptpv_pkg::ANG_W-1:0] ATAN = ptpv_pkg::atan_q20(IDX);

    logic signed [XW-1:0]              r_x, r_y, n_x, n_y;
    logic signed [ptpv_pkg::ANG_W-1:0] r_z, n_z;
    ptpv_pkg::t_side                   r_side;
    logic signed [XW-1:0]              xs, ys;

    // arithmetic shift floors, as the rotation needs
    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;

    // rotate toward the x axis
    always_comb begin
        if (i_y >= 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule
